FILE: src/rtnp_pkg.sv
// Package for the tag-notify frame parser: byte codes, flag masks, the
// token carried from the framing front end to the section parser, and the
// result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtnp_pkg;

    localparam logic [7:0] START_BYTE     = 8'hBB;
    localparam logic [7:0] CMD_TAG_NOTIFY = 8'hE0;

    localparam logic [7:0] FLAG_DEVID = 8'h40;
    localparam logic [7:0] FLAG_EPC   = 8'h01;
    localparam logic [7:0] FLAG_TID   = 8'h02;
    localparam logic [7:0] FLAG_RSSI  = 8'h04;
    localparam logic [7:0] FLAG_USER  = 8'h08;

    localparam logic [7:0] DEVID_BYTES   = 8'd4;
    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    // Length byte plus the two CRC bytes fits in nine bits.
    localparam int FRAME_CNT_W = 9;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    localparam logic [1:0] KIND_EPC  = 2'd0;
    localparam logic [1:0] KIND_TID  = 2'd1;
    localparam logic [1:0] KIND_RSSI = 2'd2;

    // One command or data byte of a frame; first marks the command byte.
    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        byte_value;
        logic signed [15:0] rssi;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

FILE: src/rtnp_front.sv
// Framing front end: start-byte hunt, length check against max_frame_len,
// frame byte count. Pushes command/data bytes as tokens. Uses rtnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtnp_front
    import rtnp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    input  wire logic [7:0] rx_byte,
    input  wire logic       queue_full,
    output logic            in_ready,
    output logic            push,
    output token_t          push_token
);

    localparam logic [1:0] ST_HUNT = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_BODY = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [FRAME_CNT_W-1:0] left_reg, left_next;
    logic                   first_reg, first_next;
    logic [7:0]             max_len_reg;
    logic                   accept;
    logic                   in_data;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign in_data  = left_reg > FRAME_CNT_W'(2);

    assign push            = accept && (state_reg == ST_BODY) && in_data;
    assign push_token.first = first_reg;
    assign push_token.data  = rx_byte;

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        first_next = first_reg;
        if (accept)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    if (rx_byte == START_BYTE)
                        state_next = ST_LEN;
                end
                ST_LEN:
                begin
                    // Drop an oversized frame, consuming its length byte.
                    if (rx_byte > max_len_reg)
                        state_next = ST_HUNT;
                    else
                    begin
                        left_next  = FRAME_CNT_W'(rx_byte) + FRAME_CNT_W'(2);
                        first_next = 1'b1;
                        state_next = ST_BODY;
                    end
                end
                ST_BODY:
                begin
                    left_next = left_reg - FRAME_CNT_W'(1);
                    if (in_data)
                        first_next = 1'b0;
                    if (left_reg == FRAME_CNT_W'(1))
                        state_next = ST_HUNT;
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            left_reg    <= '0;
            first_reg   <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            first_reg <= first_next;
            if (cfg_valid)
                max_len_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/rtnp_fifo.sv
// Short token queue between the framing front end and the section parser.
// Register array with wrap-around pointers. Uses rtnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtnp_fifo
    import rtnp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t push_token,
    input  wire logic   pop,
    output logic        full,
    output logic        pop_valid,
    output token_t      pop_token
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    token_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = count_reg == CW'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_token = mem[rd_ptr_reg];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

FILE: src/rtnp_back.sv
// Section parser: walks the tag-notify header flags over the queued bytes
// and registers EPC, TID and RSSI results. Uses rtnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtnp_back
    import rtnp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   tok_valid,
    input  wire token_t tok,
    output logic        tok_pop,
    input  wire logic   out_ready,
    output logic        out_valid,
    output result_t     result
);

    localparam logic [3:0] PH_FLAGS    = 4'd0;
    localparam logic [3:0] PH_DEVID    = 4'd1;
    localparam logic [3:0] PH_EPC_LEN  = 4'd2;
    localparam logic [3:0] PH_EPC_DATA = 4'd3;
    localparam logic [3:0] PH_TID_LEN  = 4'd4;
    localparam logic [3:0] PH_TID_DATA = 4'd5;
    localparam logic [3:0] PH_USR_LEN  = 4'd6;
    localparam logic [3:0] PH_USR_DATA = 4'd7;
    localparam logic [3:0] PH_RSSI_H   = 4'd8;
    localparam logic [3:0] PH_RSSI_L   = 4'd9;
    localparam logic [3:0] PH_SKIP     = 4'd10;

    logic [3:0] phase_reg, phase_next;
    logic [7:0] flags_reg, flags_next;
    logic [7:0] field_reg, field_next;
    logic [7:0] rssi_hi_reg, rssi_hi_next;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg, result_next;
    logic       produce;
    logic [7:0] field_dec;

    // First present section at or after s: 0 device ID, 1 EPC, 2 TID,
    // 3 user memory, 4 RSSI.
    function automatic logic [3:0] enter_section(input logic [7:0] fl,
                                                 input logic [2:0] s);
        if (s <= 3'd0 && (fl & FLAG_DEVID) != '0)
            enter_section = PH_DEVID;
        else if (s <= 3'd1 && (fl & FLAG_EPC) != '0)
            enter_section = PH_EPC_LEN;
        else if (s <= 3'd2 && (fl & FLAG_TID) != '0)
            enter_section = PH_TID_LEN;
        else if (s <= 3'd3 && (fl & FLAG_USER) != '0)
            enter_section = PH_USR_LEN;
        else if (s <= 3'd4 && (fl & FLAG_RSSI) != '0)
            enter_section = PH_RSSI_H;
        else
            enter_section = PH_SKIP;
    endfunction

    assign tok_pop   = tok_valid && (!out_valid_reg || out_ready);
    assign field_dec = field_reg - 8'd1;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        field_next   = field_reg;
        rssi_hi_next = rssi_hi_reg;
        produce      = 1'b0;
        result_next  = result_reg;
        if (tok_pop)
        begin
            if (tok.first)
            begin
                phase_next = (tok.data == CMD_TAG_NOTIFY) ? PH_FLAGS : PH_SKIP;
            end
            else
            begin
                case (phase_reg)
                    PH_FLAGS:
                    begin
                        flags_next = tok.data;
                        phase_next = enter_section(tok.data, 3'd0);
                    end
                    PH_DEVID:
                    begin
                        field_next = field_dec;
                        if (field_dec == '0)
                            phase_next = enter_section(flags_reg, 3'd1);
                    end
                    PH_EPC_LEN, PH_TID_LEN, PH_USR_LEN:
                    begin
                        if (tok.data == '0)
                        begin
                            if (phase_reg == PH_EPC_LEN)
                                phase_next = enter_section(flags_reg, 3'd2);
                            else if (phase_reg == PH_TID_LEN)
                                phase_next = enter_section(flags_reg, 3'd3);
                            else
                                phase_next = enter_section(flags_reg, 3'd4);
                        end
                        else
                        begin
                            field_next = tok.data;
                            phase_next = phase_reg + 4'd1;
                        end
                    end
                    PH_EPC_DATA, PH_TID_DATA:
                    begin
                        field_next             = field_dec;
                        produce                = 1'b1;
                        result_next.kind       = (phase_reg == PH_EPC_DATA) ? KIND_EPC
                                                                            : KIND_TID;
                        result_next.byte_value = tok.data;
                        result_next.rssi       = '0;
                        result_next.last       = field_dec == '0;
                        if (field_dec == '0)
                            phase_next = enter_section(flags_reg,
                                (phase_reg == PH_EPC_DATA) ? 3'd2 : 3'd3);
                    end
                    PH_USR_DATA:
                    begin
                        field_next = field_dec;
                        if (field_dec == '0)
                            phase_next = enter_section(flags_reg, 3'd4);
                    end
                    PH_RSSI_H:
                    begin
                        rssi_hi_next = tok.data;
                        phase_next   = PH_RSSI_L;
                    end
                    PH_RSSI_L:
                    begin
                        produce                = 1'b1;
                        result_next.kind       = KIND_RSSI;
                        result_next.byte_value = '0;
                        result_next.rssi       = {rssi_hi_reg, tok.data};
                        result_next.last       = 1'b0;
                        phase_next             = PH_SKIP;
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end
        // Device ID count is loaded on entry to its section.
        if (phase_next == PH_DEVID && phase_reg != PH_DEVID)
            field_next = DEVID_BYTES;
        if (produce)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            flags_reg     <= '0;
            field_reg     <= '0;
            rssi_hi_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            field_reg     <= field_next;
            rssi_hi_reg   <= rssi_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/rfid_tag_notify_frame_parser.sv
// Tag-notify frame parser top level: front end, token queue, section parser.
// Depends on rtnp_pkg, rtnp_front, rtnp_fifo, rtnp_back.
// Throughput: one rx_byte transaction per cycle while out_ready holds; a stalled
// output fills the FIFO_DEPTH-entry queue, then in_ready drops.
// Path: each data byte is written into the token queue; once popped, its result is registered in the output register.
// Reset: async active-low rst_n; hunt, queue empty, no result, max_frame_len 64.
`timescale 1ns / 1ps
`default_nettype none

module rfid_tag_notify_frame_parser
    import rtnp_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel: max_frame_len
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  max_frame_len,
    // Received byte stream
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // Results
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       byte_value,
    output logic signed [15:0] rssi_centi_dbm,
    output logic             last
);

    token_t  push_token;
    token_t  pop_token;
    result_t result;
    logic    push;
    logic    pop;
    logic    queue_full;
    logic    pop_valid;

    // The register is always writable; the user must write it only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    // Front end: frame the stream and queue each command/data byte.
    // CRC bytes and bytes outside a frame are consumed here and never queued.
    rtnp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (max_frame_len),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .in_ready   (in_ready),
        .push       (push),
        .push_token (push_token)
    );

    // Decouple the two sides so an output stall does not block framing
    // until the queue fills.
    rtnp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_token  (pop_token)
    );

    // Back end: walk header flag sections, register EPC, TID and RSSI results.
    rtnp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (pop_valid),
        .tok       (pop_token),
        .tok_pop   (pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign kind           = result.kind;
    assign byte_value     = result.byte_value;
    assign rssi_centi_dbm = result.rssi;
    assign last           = result.last;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for rfid_tag_notify_frame_parser: a cycle-free frame
// predictor in a small scoreboard class, plus byte, config and drain tasks.
// Depends on rtnp_pkg and the rfid_tag_notify_frame_parser RTL.
`timescale 1ns / 1ps

import rtnp_pkg::*;

// Parser position within a frame, hunt through trailing skip.
typedef enum logic [3:0] {
    P_HUNT, P_LEN, P_CMD, P_FLAGS, P_DEVID, P_EPC_LEN, P_EPC_DATA,
    P_TID_LEN, P_TID_DATA, P_USR_LEN, P_USR_DATA, P_RSSI_H, P_RSSI_L, P_SKIP
} parse_phase_t;

// Section order after the header flags.
localparam int unsigned SEC_DEVID = 0;
localparam int unsigned SEC_EPC   = 1;
localparam int unsigned SEC_TID   = 2;
localparam int unsigned SEC_USER  = 3;
localparam int unsigned SEC_RSSI  = 4;

class notify_scoreboard;
    logic [7:0]   max_len;
    parse_phase_t ph;
    logic [8:0]   frame_left;
    logic         tag_notify;
    logic [7:0]   hdr_flags;
    logic [7:0]   field_left;
    logic [7:0]   rssi_hi;
    result_t      pending[$];
    int           errors;

    function new();
        max_len    = MAX_LEN_RESET;
        ph         = P_HUNT;
        frame_left = '0;
        tag_notify = 1'b0;
        hdr_flags  = '0;
        field_left = '0;
        rssi_hi    = '0;
        errors     = 0;
    endfunction

    // Enter the first section present at or after section s.
    function void goto_section(int unsigned s);
        if (s <= SEC_DEVID && (hdr_flags & FLAG_DEVID) != 0) begin
            field_left = DEVID_BYTES;
            ph = P_DEVID;
        end
        else if (s <= SEC_EPC && (hdr_flags & FLAG_EPC) != 0)
            ph = P_EPC_LEN;
        else if (s <= SEC_TID && (hdr_flags & FLAG_TID) != 0)
            ph = P_TID_LEN;
        else if (s <= SEC_USER && (hdr_flags & FLAG_USER) != 0)
            ph = P_USR_LEN;
        else if (s <= SEC_RSSI && (hdr_flags & FLAG_RSSI) != 0)
            ph = P_RSSI_H;
        else
            ph = P_SKIP;
    endfunction

    // One command or data byte of an accepted frame.
    function void parse_data(logic [7:0] b);
        result_t r;
        case (ph)
            P_CMD:
            begin
                tag_notify = (b == CMD_TAG_NOTIFY);
                ph = tag_notify ? P_FLAGS : P_SKIP;
            end
            P_FLAGS:
            begin
                hdr_flags = b;
                goto_section(SEC_DEVID);
            end
            P_DEVID:
            begin
                field_left = field_left - 8'd1;
                if (field_left == 0)
                    goto_section(SEC_EPC);
            end
            P_EPC_LEN, P_TID_LEN:
            begin
                if (b == 0)
                    goto_section(ph == P_EPC_LEN ? SEC_TID : SEC_USER);
                else
                begin
                    field_left = b;
                    ph = (ph == P_EPC_LEN) ? P_EPC_DATA : P_TID_DATA;
                end
            end
            P_EPC_DATA, P_TID_DATA:
            begin
                field_left   = field_left - 8'd1;
                r.kind       = (ph == P_EPC_DATA) ? KIND_EPC : KIND_TID;
                r.byte_value = b;
                r.rssi       = '0;
                r.last       = (field_left == 0);
                pending.push_back(r);
                if (field_left == 0)
                    goto_section(ph == P_EPC_DATA ? SEC_TID : SEC_USER);
            end
            P_USR_LEN:
            begin
                if (b == 0)
                    goto_section(SEC_RSSI);
                else
                begin
                    field_left = b;
                    ph = P_USR_DATA;
                end
            end
            P_USR_DATA:
            begin
                field_left = field_left - 8'd1;
                if (field_left == 0)
                    goto_section(SEC_RSSI);
            end
            P_RSSI_H:
            begin
                rssi_hi = b;
                ph = P_RSSI_L;
            end
            P_RSSI_L:
            begin
                r.kind       = KIND_RSSI;
                r.byte_value = '0;
                r.rssi       = {rssi_hi, b};
                r.last       = 1'b0;
                pending.push_back(r);
                ph = P_SKIP;
            end
            default: ;
        endcase
    endfunction

    // Note one accepted rx_byte transaction and queue what it should produce.
    function void note_rx_byte(logic [7:0] b);
        logic in_data;
        if (ph == P_HUNT)
        begin
            if (b == START_BYTE)
                ph = P_LEN;
            return;
        end
        if (ph == P_LEN)
        begin
            if (b > max_len)
                ph = P_HUNT;
            else
            begin
                frame_left = {1'b0, b} + 9'd2;
                ph = P_CMD;
            end
            return;
        end
        // The two CRC bytes only count down; they are never parsed.
        in_data = (frame_left > 9'd2);
        if (frame_left != 0)
            frame_left = frame_left - 9'd1;
        if (in_data)
            parse_data(b);
        if (frame_left == 0)
            ph = P_HUNT;
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(result_t got);
        result_t exp;
        if (pending.size() == 0)
        begin
            $error("unexpected result: kind %0d byte_value %0d rssi_centi_dbm %0d last %0d",
                   got.kind, got.byte_value, got.rssi, got.last);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.kind !== exp.kind)
        begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            errors++;
        end
        if (got.byte_value !== exp.byte_value)
        begin
            $error("byte_value: expected %0d, got %0d", exp.byte_value, got.byte_value);
            errors++;
        end
        if (got.rssi !== exp.rssi)
        begin
            $error("rssi_centi_dbm: expected %0d, got %0d", exp.rssi, got.rssi);
            errors++;
        end
        if (got.last !== exp.last)
        begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb;

    // Cycle budget: about 950 bytes, each at worst waiting out long sender
    // gaps and receiver stalls; this is many times the slowest clean run.
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_LIMIT   = 5000;
    // Margin for the token queue and result register to settle after the last byte.
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 180;
    localparam int NUM_PHASES    = 5;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [7:0]         max_frame_len  = 8'd0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte        = 8'd0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic [1:0]         kind;
    logic [7:0]         byte_value;
    logic signed [15:0] rssi_centi_dbm;
    logic               last;

    notify_scoreboard board;
    result_t          seen_result;
    logic [7:0]       frame_q[$];
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               cycle_count = 0;

    rfid_tag_notify_frame_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_frame_len  (max_frame_len),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .byte_value     (byte_value),
        .rssi_centi_dbm (rssi_centi_dbm),
        .last           (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("rfid_tag_notify_frame_parser regression: fail");
            $finish;
        end
    end

    // Receiver: stall at random according to the current phase.
    always @(posedge clk)
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // Sample the result channel mid-cycle: a transaction seen here completes
    // at the next rising edge, since nothing on it moves before then.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_result.kind       = kind;
            seen_result.byte_value = byte_value;
            seen_result.rssi       = rssi_centi_dbm;
            seen_result.last       = last;
            board.check_result(seen_result);
        end
    end

    // Present one byte, optionally after an idle gap, and hold it until taken.
    // Drop valid only when a gap is inserted, so valid never toggles within
    // a single time step between back-to-back transactions.
    task automatic send_byte(input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        board.note_rx_byte(b);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
    endtask

    // Write max_frame_len; called only while the parser is quiet.
    task automatic write_max_len(input logic [7:0] v);
        cfg_valid     <= 1'b1;
        max_frame_len <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        board.max_len = v;
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every expected result, then let the pipe settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (board.pending.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Length byte plus payload for an optional section; mostly short,
    // sometimes empty, sometimes long enough to be cut off by the frame end.
    function automatic void add_field(ref logic [7:0] body[$]);
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(99);
        if (roll < 10)
            n = 0;
        else if (roll < 20)
            n = $urandom_range(255);
        else
            n = $urandom_range(1, 12);
        body.push_back(n[7:0]);
        repeat (n) body.push_back(8'($urandom_range(255)));
    endfunction

    // Well-formed tag-notify frame with random flags and content; the length
    // byte usually matches, sometimes truncates or pads the body.
    function automatic void build_tag_frame(input logic [7:0] cap);
        logic [7:0]  body[$];
        logic [7:0]  flags;
        int unsigned flen;
        int unsigned mode;
        flags = 8'($urandom_range(255));
        body.push_back(CMD_TAG_NOTIFY);
        body.push_back(flags);
        if ((flags & FLAG_DEVID) != 0)
            repeat (DEVID_BYTES) body.push_back(8'($urandom_range(255)));
        if ((flags & FLAG_EPC) != 0)
            add_field(body);
        if ((flags & FLAG_TID) != 0)
            add_field(body);
        if ((flags & FLAG_USER) != 0)
            add_field(body);
        if ((flags & FLAG_RSSI) != 0)
            repeat (2) body.push_back(8'($urandom_range(255)));
        mode = $urandom_range(99);
        if (mode < 70)
            flen = body.size();
        else if (mode < 85)
            flen = $urandom_range(body.size());
        else
            flen = body.size() + $urandom_range(1, 6);
        if (flen > cap)
            flen = cap;
        frame_q.push_back(START_BYTE);
        frame_q.push_back(flen[7:0]);
        for (int i = 0; i < flen; i++)
            frame_q.push_back(i < body.size() ? body[i] : 8'($urandom_range(255)));
        repeat (2) frame_q.push_back(8'($urandom_range(255)));
    endfunction

    // Random traffic: mostly tag-notify frames, the rest noise, other
    // commands and oversized lengths that must be dropped.
    task automatic send_random(input int n_items);
        int          counted;
        int unsigned roll;
        int unsigned flen;
        logic [7:0]  cmd;
        counted = 0;
        while (counted < n_items)
        begin
            frame_q.delete();
            roll = $urandom_range(99);
            if (roll < 8 || (roll < 16 && board.max_len == 8'hFF))
            begin
                repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(255)));
                send_frame();
                continue;
            end
            else if (roll < 16)
            begin
                frame_q.push_back(START_BYTE);
                frame_q.push_back(8'($urandom_range(board.max_len + 1, 255)));
                repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(255)));
            end
            else if (roll < 26)
            begin
                do
                    cmd = 8'($urandom_range(255));
                while (cmd == CMD_TAG_NOTIFY);
                flen = $urandom_range(board.max_len < 8'd10 ? board.max_len : 10);
                frame_q.push_back(START_BYTE);
                frame_q.push_back(flen[7:0]);
                if (flen != 0)
                    frame_q.push_back(cmd);
                repeat (flen > 1 ? flen - 1 : 0) frame_q.push_back(8'($urandom_range(255)));
                repeat (2) frame_q.push_back(8'($urandom_range(255)));
            end
            else
                build_tag_frame(board.max_len);
            counted += frame_q.size();
            send_frame();
        end
    endtask

    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit of 64.
        write_max_len(MAX_LEN_RESET);
        frame_q = {
            // noise while hunting
            8'h00,
            // start byte, then 0xBB as an oversized length: consumed and dropped
            START_BYTE, START_BYTE,
            // zero length: only the CRC follows
            START_BYTE, 8'h00, 8'hFF, 8'hFF,
            // every section present, empty TID field, most negative RSSI
            START_BYTE, 8'h0E, CMD_TAG_NOTIFY, 8'h4F,
            8'hA5, START_BYTE, 8'h5A, 8'hC3,
            8'h02, 8'h00, 8'hFF,
            8'h00,
            8'h01, 8'h5A,
            8'h80, 8'h00,
            START_BYTE, CMD_TAG_NOTIFY,
            // other command, skipped to frame end
            START_BYTE, 8'h01, 8'h22, 8'h00, 8'h00,
            // RSSI cut short by the data end: nothing emitted
            START_BYTE, 8'h03, CMD_TAG_NOTIFY, 8'h04, 8'h7F, 8'h01, 8'h01
        };
        send_frame();
        drain_results();

        // Random phases: each pairs a limit setting with an idling mix.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    write_max_len(8'hFF);
                end
                1:
                begin
                    idle_pct = 56;
                    stall_pct = 0;
                    write_max_len(8'h00);
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 56;
                    write_max_len(8'($urandom_range(1, 254)));
                end
                3:
                begin
                    idle_pct = 31;
                    stall_pct = 31;
                    write_max_len(8'($urandom_range(8, 40)));
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    write_max_len(8'($urandom_range(16, 128)));
                end
            endcase
            send_random(PHASE_ITEMS);
            drain_results();
        end

        if (board.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", board.pending.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("rfid_tag_notify_frame_parser regression: pass");
        else
            $display("rfid_tag_notify_frame_parser regression: fail");
        $finish;
    end

endmodule
